>>> design/assert_macros.svh
// Assertion macros shared by the decimal conversion RTL.
// Expects clk and rst (synchronous, active high) in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ITOA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ITOA_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> design/itoa_pkg.sv
// Package for the signed integer to ASCII decimal converter.
// Constants and helpers shared by front, queue and back; no dependencies.
`timescale 1ns / 1ps

package itoa_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int BCD_DIGIT_W     = 4;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Decimal digits needed for a magnitude of up to 2^(width-1).
  // 1233/4096 slightly under log10(2); an extra digit only adds a leading zero.
  function automatic int num_digits(input int width);
    return ((width * 1233) >> 12) + 1;
  endfunction

endpackage

>>> design/signed_int_to_ascii_decimal.sv
// Top level of the signed integer to ASCII decimal converter.
// Instantiates itoa_front, itoa_queue and itoa_back; uses itoa_pkg.
`timescale 1ns / 1ps

// Usage:
//   Slave stream (s_t*): one item per integer, two's complement in the low
//   VALUE_WIDTH bits of s_tdata; bits above are ignored.
//   Master stream (m_t*): one item per ASCII character, most significant
//   digit first, '-' ahead of a negative number; m_tlast marks the final
//   digit. Zero gives a single '0'; leading zeros never appear.
// Timing:
//   The front negates to a magnitude and writes a two-entry queue, so up to
//   two integers can be taken while the back is busy.
//   The back pops one entry, runs the shift-and-add-3 loop (one input bit
//   per cycle), loads a sign for a negative number, then steps through each
//   possible digit (num_digits(VALUE_WIDTH), 10 at 32 bits) to emit or skip
//   it. It pops the next entry only once the last digit of the previous
//   integer has entered the output register.
// Reset: rst (synchronous, active high) empties the queue, drops any output
//   item and returns the back to idle.
// Stall: a low m_tready freezes emission in the output register; the queue
//   then fills and s_tready falls.
module signed_int_to_ascii_decimal import itoa_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int IN_W        = ((VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [IN_W-1:0] s_tdata,   // [VALUE_WIDTH-1:0] value, rest zero fill
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [7:0]      m_tdata,   // [7:0] character
  output logic            m_tlast
);

  logic                 push_valid;
  logic                 push_ready;
  logic [VALUE_WIDTH:0] push_data;
  logic                 pop_valid;
  logic                 pop_ready;
  logic [VALUE_WIDTH:0] pop_data;

  itoa_front #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .IN_W        (IN_W)
  ) u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  itoa_queue #(
    .DATA_W (VALUE_WIDTH + 1),
    .DEPTH  (QUEUE_DEPTH_DEF)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  itoa_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

>>> design/itoa_front.sv
// Front end: takes input items and splits them into sign and magnitude.
// Depends on itoa_pkg; feeds itoa_queue.
`timescale 1ns / 1ps

module itoa_front import itoa_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int IN_W        = ((VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_W-1:0]        s_tdata,    // [VALUE_WIDTH-1:0] value
  output logic                   push_valid,
  input  logic                   push_ready,
  output logic [VALUE_WIDTH:0]   push_data   // {negative, magnitude}
);

  logic [VALUE_WIDTH-1:0] raw;
  logic                   negative;
  logic [VALUE_WIDTH-1:0] magnitude;

  assign raw       = s_tdata[VALUE_WIDTH-1:0];
  assign negative  = raw[VALUE_WIDTH-1];
  // Unsigned negate: the most negative value maps to 2^(W-1) exactly.
  assign magnitude = negative ? (~raw + VALUE_WIDTH'(1)) : raw;

  assign push_valid = s_tvalid;
  assign s_tready   = push_ready;
  assign push_data  = {negative, magnitude};

endmodule

>>> design/itoa_queue.sv
// Short FIFO between front and back so each side stalls on its own.
// Depends on itoa_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module itoa_queue import itoa_pkg::*; #(
  parameter int DATA_W = VALUE_WIDTH_DEF + 1,
  parameter int DEPTH  = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  logic [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output logic [DATA_W-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              push;
  logic              pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  `ITOA_ASSERT(a_count_bound, count <= CNT_W'(DEPTH), "queue fill count over depth")
  `ITOA_ASSERT(a_push_counts, (push && !pop) |=> count == $past(count) + CNT_W'(1), "queue lost a push")

endmodule

>>> design/itoa_back.sv
// Back end: binary to BCD by shift-and-add-3, one bit a cycle, then emits
// sign and digits through an output register. Depends on itoa_pkg, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module itoa_back import itoa_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  logic [VALUE_WIDTH:0] pop_data,   // {negative, magnitude}
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,    // [7:0] character
  output logic                 m_tlast
);

  localparam int ND    = num_digits(VALUE_WIDTH);
  localparam int BCD_W = BCD_DIGIT_W * ND;
  localparam int CNT_W = $clog2(VALUE_WIDTH);
  localparam int IDX_W = $clog2(ND);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SIGN = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t                 state;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   negative;
  logic [BCD_W-1:0]       bcd;
  logic [BCD_W-1:0]       bcd_adj;
  logic [CNT_W-1:0]       cnt;
  logic [IDX_W-1:0]       idx;
  logic                   started;
  logic [3:0]             top_digit;
  logic                   skip;
  logic                   can_load;
  logic                   load;

  // Add 3 to every digit of 5 or more before the shift.
  always_comb begin
    bcd_adj = bcd;
    for (int d = 0; d < ND; d++) begin
      if (bcd[d*BCD_DIGIT_W +: BCD_DIGIT_W] >= 4'd5) begin
        bcd_adj[d*BCD_DIGIT_W +: BCD_DIGIT_W] = bcd[d*BCD_DIGIT_W +: BCD_DIGIT_W] + 4'd3;
      end
    end
  end

  assign top_digit = bcd[BCD_W-1 -: BCD_DIGIT_W];
  // Leading zeros are dropped, but the units digit always goes out.
  assign skip      = !started && (top_digit == 4'd0) && (idx != '0);
  assign can_load  = !m_tvalid || m_tready;
  // A character enters the output register this cycle.
  assign load      = can_load && ((state == ST_SIGN) || ((state == ST_EMIT) && !skip));
  assign pop_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop_valid) begin
            negative <= pop_data[VALUE_WIDTH];
            mag      <= pop_data[VALUE_WIDTH-1:0];
            bcd      <= '0;
            cnt      <= '0;
            state    <= ST_CONV;
          end
        end
        ST_CONV: begin
          bcd     <= {bcd_adj[BCD_W-2:0], mag[VALUE_WIDTH-1]};
          mag     <= {mag[VALUE_WIDTH-2:0], 1'b0};
          cnt     <= cnt + CNT_W'(1);
          idx     <= IDX_W'(ND - 1);
          started <= 1'b0;
          if (cnt == CNT_W'(VALUE_WIDTH - 1)) begin
            state <= negative ? ST_SIGN : ST_EMIT;
          end
        end
        ST_SIGN: begin
          if (can_load) begin
            m_tdata  <= CHAR_MINUS;
            m_tlast  <= 1'b0;
            state    <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (skip) begin
            bcd <= {bcd[BCD_W-BCD_DIGIT_W-1:0], {BCD_DIGIT_W{1'b0}}};
            idx <= idx - IDX_W'(1);
          end else if (can_load) begin
            m_tdata  <= CHAR_ZERO + {4'b0, top_digit};
            m_tlast  <= (idx == '0);
            started  <= 1'b1;
            bcd      <= {bcd[BCD_W-BCD_DIGIT_W-1:0], {BCD_DIGIT_W{1'b0}}};
            if (idx == '0) begin
              state <= ST_IDLE;
            end else begin
              idx <= idx - IDX_W'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ITOA_ASSERT(a_char_legal, m_tvalid |-> (m_tdata == CHAR_MINUS || (m_tdata >= CHAR_ZERO && m_tdata <= CHAR_NINE)), "character is not a digit or minus")
  `ITOA_NEVER(a_sign_not_last, m_tvalid && m_tlast && (m_tdata == CHAR_MINUS), "minus sign marked last")

endmodule

>>> verif/itoa_text_checker.sv
// Checker for signed_int_to_ascii_decimal: predicts the decimal text of each
// accepted integer and compares it with the character stream. Uses itoa_pkg.
`timescale 1ns / 1ps

module itoa_text_checker import itoa_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  input  logic                       s_tready,
  input  logic [VALUE_WIDTH_DEF-1:0] s_tdata,
  input  logic                       m_tvalid,
  input  logic                       m_tready,
  input  logic [7:0]                 m_tdata,
  input  logic                       m_tlast,
  output int                         mismatches,
  output int                         chars_pending
);

  localparam int MAX_DIGITS = 10;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  text_char_t expected_text[$];
  int         err_cnt = 0;

  // Queue the characters of one integer, sign first, most significant digit next.
  function automatic void queue_decimal_text(input logic [VALUE_WIDTH_DEF-1:0] value);
    logic [VALUE_WIDTH_DEF-1:0] mag;
    logic [3:0]                 digs[MAX_DIGITS];
    int                         n;
    text_char_t                 c;
    mag = value[VALUE_WIDTH_DEF-1] ? -value : value;  // unsigned, so -2^31 stays 2^31
    n = 0;
    do begin
      digs[n] = 4'(mag % 10);
      mag     = mag / 10;
      n++;
    end while (mag != 0);
    if (value[VALUE_WIDTH_DEF-1]) begin
      c.ch   = CHAR_MINUS;
      c.last = 1'b0;
      expected_text.push_back(c);
    end
    for (int k = n - 1; k >= 0; k--) begin
      c.ch   = CHAR_ZERO + 8'(digs[k]);
      c.last = (k == 0);
      expected_text.push_back(c);
    end
  endfunction

  always @(posedge clk) begin
    text_char_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) queue_decimal_text(s_tdata);
      if (m_tvalid && m_tready) begin
        if (expected_text.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected char: expected none, got ch=%h last=%b",
                   $time, m_tdata, m_tlast);
        end else begin
          want = expected_text.pop_front();
          if (want.ch !== m_tdata || want.last !== m_tlast) begin
            err_cnt++;
            $display("%0t: mismatch: expected ch=%h last=%b, got ch=%h last=%b",
                     $time, want.ch, want.last, m_tdata, m_tlast);
          end
        end
      end
    end
    mismatches    <= err_cnt;
    chars_pending <= expected_text.size();
  end

endmodule

>>> verif/signed_int_to_ascii_decimal_tb.sv
// Testbench top for signed_int_to_ascii_decimal: drives integers, stalls the
// character stream and gives the verdict. Needs itoa_text_checker and itoa_pkg.
`timescale 1ns / 1ps

module signed_int_to_ascii_decimal_tb import itoa_pkg::*;;

  localparam int W = VALUE_WIDTH_DEF;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [W-1:0] s_tdata = '0;     // [31:0] value
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [7:0]   m_tdata;          // [7:0] character
  logic         m_tlast;

  int mismatches;
  int chars_pending;

  // idle enables for each side; cleared for the no-gap stretch
  bit send_gaps = 1'b1;
  bit sink_gaps = 1'b1;

  always #1 clk = ~clk;

  signed_int_to_ascii_decimal DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  itoa_text_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .mismatches    (mismatches),
    .chars_pending (chars_pending)
  );

  // Sink backpressure: ~15% stall cycles while enabled.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= !sink_gaps || ($urandom_range(99) >= 15);
    end
  end

  // Hand one integer to the block. valid only drops when a gap is inserted,
  // so it never falls and rises in the same step.
  task automatic send_value(input logic [W-1:0] v);
    if (send_gaps && $urandom_range(99) < 15) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    // ready is stable at the falling edge; the item goes at the next rising one
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
  endtask

  // Random integer: often spread over digit counts so short and long texts
  // both show up, otherwise raw 32 bits.
  function automatic logic [W-1:0] random_value();
    int unsigned lo, hi, n, v;
    if ($urandom_range(3) == 0) return $urandom;
    n  = $urandom_range(1, 10);
    lo = 1;
    for (int i = 1; i < n; i++) lo = lo * 10;
    hi = (n == 10) ? 32'h8000_0000 : lo * 10 - 1;
    if (n == 1) lo = 0;
    v = $urandom_range(hi, lo);
    // 2^31 only makes sense as the negative extreme
    if (v == 32'h8000_0000 || $urandom_range(1)) return -v;
    return v;
  endfunction

  // One edge first so the checker has counted the item taken at this edge.
  task automatic wait_for_drain();
    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
  endtask

  initial begin
    logic [W-1:0] directed[$];
    directed = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
                 32'd999999999, -32'sd999999999, 32'd1234567890, 32'h5555_5555,
                 32'hAAAA_AAAA, 32'd5, -32'sd5, 32'hFFFF_FFF6};

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners: zero, single digits, decade edges, both extremes
    foreach (directed[i]) send_value(directed[i]);

    // random with gaps on both sides
    repeat (100) send_value(random_value());

    // no-gap stretch: block runs back to back, output never stalls
    send_gaps = 1'b0;
    sink_gaps = 1'b0;
    repeat (80) send_value(random_value());

    // hold off until all text has drained, then resume with gaps
    s_tvalid <= 1'b0;
    wait_for_drain();
    send_gaps = 1'b1;
    sink_gaps = 1'b1;
    repeat (80) send_value(random_value());

    s_tvalid <= 1'b0;
    wait_for_drain();
    repeat (60) @(posedge clk);  // room for any stray character

    if (mismatches == 0 && chars_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: stops the run and reports failure if it hangs.
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/itoa_pkg.sv
design/itoa_front.sv
design/itoa_queue.sv
design/itoa_back.sv
design/signed_int_to_ascii_decimal.sv
verif/itoa_text_checker.sv
verif/signed_int_to_ascii_decimal_tb.sv
